@@ src/fkvjs_pkg.sv @@
package fkvjs_pkg;

  // Field widths
  localparam int unsigned CH_W     = 8;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned SPAN_W   = 12;

  // Default message length limit in bytes
  localparam int unsigned MAX_LEN_DEF = 4096;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_RUNNING  = 4'd0;
  localparam logic [STATUS_W-1:0] ST_SUCCESS  = 4'd1;
  localparam logic [STATUS_W-1:0] ST_ERR_BASE = 4'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 4'd11;

  // Characters of the message grammar
  localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CH_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_NL     = 8'h0A;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            first;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pair_valid;
    logic [SPAN_W-1:0]   key_pos;
    logic [SPAN_W-1:0]   key_len;
    logic [SPAN_W-1:0]   value_pos;
    logic [SPAN_W-1:0]   value_len;
  } out_t;

  // Letter or underscore
  function automatic logic is_name_char(input logic [CH_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  // Space, newline or tab
  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
  endfunction

endpackage

@@ src/flat_key_value_json_scanner.sv @@
// A byte's result goes to the output register, or to the skid stage if stalled.
// Throughput: one byte per cycle when not stalled; the scan state is one register
// stage updated by the grammar logic, followed by an output register and a
// one-entry skid stage. The input stalls only while the skid stage holds a result.
// Reset (rst_ni low, asynchronous): stage 0, status running, offsets and spans
// zero, both output stages empty.
module flat_key_value_json_scanner #(
  parameter int unsigned MAX_LEN = fkvjs_pkg::MAX_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fkvjs_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fkvjs_pkg::out_t  out_data_o
);
  import fkvjs_pkg::*;

  logic in_xfer;
  logic out_free;
  out_t res;
  out_t out_q, out_d;
  out_t skid_q, skid_d;
  logic out_vq, out_vd;
  logic skid_vq, skid_vd;

  assign in_stall_o = skid_vq;
  assign in_xfer    = in_valid_i && !skid_vq;
  assign out_free   = !out_vq || !out_stall_i;

  fkvjs_scan #(
    .MAX_LEN(MAX_LEN)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_xfer),
    .in_i  (in_data_i),
    .res_o (res)
  );

  // Steer results between the output register and the skid stage
  always_comb begin
    out_d   = out_q;
    skid_d  = skid_q;
    out_vd  = out_vq;
    skid_vd = skid_vq;
    if (out_free) begin
      out_vd  = skid_vq || in_xfer;
      out_d   = skid_vq ? skid_q : res;
      skid_vd = 1'b0;
    end else if (in_xfer) begin
      skid_d  = res;
      skid_vd = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else begin
      out_vq  <= out_vd;
      skid_vq <= skid_vd;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vq;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vq |-> out_vq)
    else $error("skid stage full while output register empty");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && !out_stall_i && skid_vq) |=> (out_vq && !skid_vq && out_q == $past(skid_q)))
    else $error("skid stage did not move forward on output transfer");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && out_stall_i && in_xfer) |=> (skid_vq && out_q == $past(out_q)))
    else $error("result lost while output stalled");

endmodule

@@ src/fkvjs_scan.sv @@
module fkvjs_scan #(
  parameter int unsigned MAX_LEN = fkvjs_pkg::MAX_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  fkvjs_pkg::in_t   in_i,
  output fkvjs_pkg::out_t  res_o
);
  import fkvjs_pkg::*;

  localparam int unsigned OFF_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned STAGE_W = 4;
  localparam logic [OFF_W-1:0] MaxLenW = OFF_W'(MAX_LEN);

  // Parse stages
  localparam logic [STAGE_W-1:0] STG_OPEN   = 4'd0;
  localparam logic [STAGE_W-1:0] STG_KQUOTE = 4'd1;
  localparam logic [STAGE_W-1:0] STG_KFIRST = 4'd2;
  localparam logic [STAGE_W-1:0] STG_KEY    = 4'd3;
  localparam logic [STAGE_W-1:0] STG_COLON  = 4'd4;
  localparam logic [STAGE_W-1:0] STG_VQUOTE = 4'd5;
  localparam logic [STAGE_W-1:0] STG_VFIRST = 4'd6;
  localparam logic [STAGE_W-1:0] STG_VALUE  = 4'd7;
  localparam logic [STAGE_W-1:0] STG_SEP    = 4'd8;

  logic [STAGE_W-1:0]  stage_q, stage_c, stage_d;
  logic [STATUS_W-1:0] final_q, final_c, final_d, err_code;
  logic [OFF_W-1:0]    offset_q, offset_c, offset_d;
  logic [OFF_W-1:0]    kbeg_q, kbeg_c, kbeg_d;
  logic [OFF_W-1:0]    klen_q, klen_c, klen_d;
  logic [OFF_W-1:0]    vbeg_q, vbeg_c, vbeg_d;
  logic [OFF_W-1:0]    vlen;
  logic                pair;
  logic                fail;
  logic                name_ch;

  // A start mark scans from a fresh state
  assign stage_c  = in_i.first ? STG_OPEN   : stage_q;
  assign final_c  = in_i.first ? ST_RUNNING : final_q;
  assign offset_c = in_i.first ? '0 : offset_q;
  assign kbeg_c   = in_i.first ? '0 : kbeg_q;
  assign klen_c   = in_i.first ? '0 : klen_q;
  assign vbeg_c   = in_i.first ? '0 : vbeg_q;

  assign name_ch  = is_name_char(in_i.ch);
  assign err_code = (stage_c > STG_SEP) ? (ST_ERR_BASE + STATUS_W'(STG_SEP))
                                        : (ST_ERR_BASE + STATUS_W'(stage_c));

  // Advance the grammar by one byte
  always_comb begin
    stage_d  = stage_c;
    final_d  = final_c;
    offset_d = offset_c;
    kbeg_d   = kbeg_c;
    klen_d   = klen_c;
    vbeg_d   = vbeg_c;
    vlen     = '0;
    pair     = 1'b0;
    fail     = 1'b0;
    if (final_c == ST_RUNNING) begin
      if (offset_c >= MaxLenW) begin
        final_d = ST_OVERFLOW;
      end else if (is_blank(in_i.ch)) begin
        offset_d = offset_c + 1'b1;
      end else begin
        unique case (stage_c)
          STG_OPEN: begin
            if (in_i.ch == CH_LBRACE) stage_d = STG_KQUOTE;
            else fail = 1'b1;
          end
          STG_KQUOTE: begin
            if (in_i.ch == CH_QUOTE) stage_d = STG_KFIRST;
            else fail = 1'b1;
          end
          STG_KFIRST: begin
            if (name_ch) begin
              kbeg_d  = offset_c;
              stage_d = STG_KEY;
            end else begin
              fail = 1'b1;
            end
          end
          STG_KEY: begin
            if (in_i.ch == CH_QUOTE) begin
              klen_d  = offset_c - kbeg_c;
              stage_d = STG_COLON;
            end else if (!name_ch) begin
              fail = 1'b1;
            end
          end
          STG_COLON: begin
            if (in_i.ch == CH_COLON) stage_d = STG_VQUOTE;
            else fail = 1'b1;
          end
          STG_VQUOTE: begin
            if (in_i.ch == CH_QUOTE) stage_d = STG_VFIRST;
            else fail = 1'b1;
          end
          STG_VFIRST: begin
            if (name_ch) begin
              vbeg_d  = offset_c;
              stage_d = STG_VALUE;
            end else begin
              fail = 1'b1;
            end
          end
          STG_VALUE: begin
            if (in_i.ch == CH_QUOTE) begin
              pair    = 1'b1;
              vlen    = offset_c - vbeg_c;
              stage_d = STG_SEP;
            end else if (!name_ch) begin
              fail = 1'b1;
            end
          end
          STG_SEP: begin
            if (in_i.ch == CH_COMMA) stage_d = STG_KQUOTE;
            else if (in_i.ch == CH_RBRACE) final_d = ST_SUCCESS;
            else fail = 1'b1;
          end
          default: fail = 1'b1;
        endcase
        if (fail) final_d = err_code;
        offset_d = offset_c + 1'b1;
      end
    end
  end

  // Result of this byte; spans only on a completed pair
  assign res_o.status     = final_d;
  assign res_o.pair_valid = pair;
  assign res_o.key_pos    = pair ? SPAN_W'(kbeg_c) : '0;
  assign res_o.key_len    = pair ? SPAN_W'(klen_c) : '0;
  assign res_o.value_pos  = pair ? SPAN_W'(vbeg_c) : '0;
  assign res_o.value_len  = pair ? SPAN_W'(vlen)   : '0;

  // Commit the scan state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= STG_OPEN;
      final_q  <= ST_RUNNING;
      offset_q <= '0;
      kbeg_q   <= '0;
      klen_q   <= '0;
      vbeg_q   <= '0;
    end else if (step_i) begin
      stage_q  <= stage_d;
      final_q  <= final_d;
      offset_q <= offset_d;
      kbeg_q   <= kbeg_d;
      klen_q   <= klen_d;
      vbeg_q   <= vbeg_d;
    end
  end

  a_final_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !in_i.first && final_q != ST_RUNNING) |=> (final_q == $past(final_q)))
    else $error("final status changed without a start mark");

  a_offset_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q <= MaxLenW)
    else $error("offset ran past the length limit");

  a_pair_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && pair) |=> (final_q == ST_RUNNING && stage_q == STG_SEP))
    else $error("pair reported outside the separator stage");

  a_key_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q == STG_VALUE || stage_q == STG_SEP) |-> (vbeg_q > kbeg_q))
    else $error("value starts before its key");

endmodule

@@ tb/sv/tb_flat_key_value_json_scanner.sv @@
`timescale 1ns / 100ps

module tb_flat_key_value_json_scanner;
  import fkvjs_pkg::*;

  localparam int unsigned SCAN_LIMIT   = MAX_LEN_DEF;
  localparam int          HOLD_CYCLES  = 90;
  localparam int          RANDOM_ITEMS = 1950;

  // Grammar position of the scanner
  typedef enum logic [3:0] {
    S_OPEN, S_KEY_QUOTE, S_KEY_FIRST, S_KEY, S_COLON,
    S_VAL_QUOTE, S_VAL_FIRST, S_VAL, S_NEXT
  } scan_stage_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall_o;
  in_t  in_data;
  logic out_valid_o;
  logic out_stall;
  out_t out_data_o;

  // Scan state of the predictor
  scan_stage_e         scan_stage;
  logic [STATUS_W-1:0] scan_code;
  int unsigned         scan_pos;
  int unsigned         key_start;
  int unsigned         key_span;
  int unsigned         value_start;

  out_t        expected_scan_q[$];
  logic [7:0]  msg_bytes[$];
  int          mismatch_count;
  int          burst_left;
  logic        hold_req;

  flat_key_value_json_scanner #(
    .MAX_LEN(SCAN_LIMIT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report(input string msg);
    if (mismatch_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic letter_or_under(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic void clear_scan();
    scan_stage  = S_OPEN;
    scan_code   = ST_RUNNING;
    scan_pos    = 0;
    key_start   = 0;
    key_span    = 0;
    value_start = 0;
  endfunction

  // Advance the scan by one byte and return the result it produces
  function automatic out_t scan_byte(input in_t item);
    out_t res;
    logic bad;
    logic [7:0] c;
    res = '0;
    bad = 1'b0;
    c   = item.ch;
    if (item.first) clear_scan();
    if (scan_code == ST_RUNNING) begin
      if (scan_pos >= SCAN_LIMIT) begin
        scan_code = ST_OVERFLOW;
      end else if (c == CH_SPACE || c == CH_NL || c == CH_TAB) begin
        scan_pos++;
      end else begin
        case (scan_stage)
          S_OPEN: begin
            if (c == CH_LBRACE) scan_stage = S_KEY_QUOTE; else bad = 1'b1;
          end
          S_KEY_QUOTE: begin
            if (c == CH_QUOTE) scan_stage = S_KEY_FIRST; else bad = 1'b1;
          end
          S_KEY_FIRST: begin
            if (letter_or_under(c)) begin
              key_start  = scan_pos;
              scan_stage = S_KEY;
            end else bad = 1'b1;
          end
          S_KEY: begin
            if (c == CH_QUOTE) begin
              key_span   = scan_pos - key_start;
              scan_stage = S_COLON;
            end else if (!letter_or_under(c)) bad = 1'b1;
          end
          S_COLON: begin
            if (c == CH_COLON) scan_stage = S_VAL_QUOTE; else bad = 1'b1;
          end
          S_VAL_QUOTE: begin
            if (c == CH_QUOTE) scan_stage = S_VAL_FIRST; else bad = 1'b1;
          end
          S_VAL_FIRST: begin
            if (letter_or_under(c)) begin
              value_start = scan_pos;
              scan_stage  = S_VAL;
            end else bad = 1'b1;
          end
          S_VAL: begin
            if (c == CH_QUOTE) begin
              res.pair_valid = 1'b1;
              res.key_pos    = key_start[SPAN_W-1:0];
              res.key_len    = key_span[SPAN_W-1:0];
              res.value_pos  = value_start[SPAN_W-1:0];
              res.value_len  = 12'(scan_pos - value_start);
              scan_stage     = S_NEXT;
            end else if (!letter_or_under(c)) bad = 1'b1;
          end
          default: begin
            if (c == CH_COMMA) scan_stage = S_KEY_QUOTE;
            else if (c == CH_RBRACE) scan_code = ST_SUCCESS;
            else bad = 1'b1;
          end
        endcase
        if (bad) scan_code = ST_ERR_BASE + scan_stage;
        scan_pos++;
      end
    end
    res.status = scan_code;
    return res;
  endfunction

  // Offer one byte, idling between bursts; return at the accepting edge
  task automatic send_byte(input logic [7:0] c, input logic mark);
    in_t item;
    int  gap;
    item.ch    = c;
    item.first = mark;
    @(negedge clk_i);
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_scan_q.push_back(scan_byte(item));
    burst_left--;
  endtask

  task automatic send_text(input string s, input logic mark);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], mark && i == 0);
  endtask

  function automatic logic [7:0] pick_name_char();
    int n;
    n = $urandom_range(0, 52);
    if (n < 26) return 8'h61 + n[7:0];
    if (n < 52) return 8'h41 + n[7:0] - 8'd26;
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_NL;
      default: return CH_TAB;
    endcase
  endfunction

  function automatic void push_pad();
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 3)) msg_bytes.push_back(pick_blank());
    end
  endfunction

  // Name starts with a letter or underscore so that blanks never form the whole name
  function automatic void push_name(input int len);
    msg_bytes.push_back(pick_name_char());
    for (int i = 1; i < len; i++) begin
      msg_bytes.push_back(($urandom_range(0, 9) == 0) ? pick_blank() : pick_name_char());
    end
  endfunction

  // Assemble a well-formed object with random names and spacing
  function automatic void build_message(input int pairs);
    msg_bytes.delete();
    push_pad();
    msg_bytes.push_back(CH_LBRACE);
    for (int p = 0; p < pairs; p++) begin
      push_pad();
      msg_bytes.push_back(CH_QUOTE);
      push_pad();
      push_name($urandom_range(1, 12));
      msg_bytes.push_back(CH_QUOTE);
      push_pad();
      msg_bytes.push_back(CH_COLON);
      push_pad();
      msg_bytes.push_back(CH_QUOTE);
      push_name($urandom_range(1, 12));
      msg_bytes.push_back(CH_QUOTE);
      push_pad();
      if (p < pairs - 1) msg_bytes.push_back(CH_COMMA);
    end
    msg_bytes.push_back(CH_RBRACE);
  endfunction

  task automatic send_message(input logic mark);
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], mark && i == 0);
  endtask

  // Scan right out of reset without a start mark
  task automatic test_no_start_mark();
    send_text("{\"az\":\"AZ_\"}", 1'b0);
  endtask

  // Blanks inside and around names, several pairs, ignored bytes after success
  task automatic test_pairs_and_blanks();
    send_text("{ \"k e\ty\" :\n\"v_Z\" , \"_\":\"Q\"}", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LBRACE, 1'b0);
  endtask

  // Fail at each grammar stage, the key on a zero byte and the value on an 0xFF
  task automatic test_stage_errors();
    send_text("X", 1'b1);
    send_text("{:", 1'b1);
    send_text("{\"\"", 1'b1);
    send_text("{\"ab", 1'b1);
    send_byte(8'h00, 1'b0);
    send_text("{\"a\"X", 1'b1);
    send_text("{\"a\":x", 1'b1);
    send_text("{\"a\":\"\"", 1'b1);
    send_text("{\"a\":\"b", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_text("{\"a\":\"b\":", 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // Restart in the middle of an object
  task automatic test_restart();
    send_text("{\"ab\":\"c", 1'b1);
    send_text("{\"d\":\"e\"}", 1'b1);
  endtask

  // Long spans, then pad the message until the offset runs out
  task automatic test_overflow();
    msg_bytes.delete();
    msg_bytes.push_back(CH_LBRACE);
    msg_bytes.push_back(CH_QUOTE);
    push_name(2000);
    msg_bytes.push_back(CH_QUOTE);
    msg_bytes.push_back(CH_COLON);
    msg_bytes.push_back(CH_QUOTE);
    push_name(2000);
    msg_bytes.push_back(CH_QUOTE);
    send_message(1'b1);
    while (scan_pos < SCAN_LIMIT) send_byte(pick_blank(), 1'b0);
    send_byte(CH_COMMA, 1'b0);
    send_byte(CH_RBRACE, 1'b0);
  endtask

  // Hold the output off while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    build_message(4);
    send_message(1'b1);
  endtask

  // Mostly well-formed objects with random content, some broken, some noise
  task automatic test_random_messages();
    int sent;
    int next_hold;
    int kind;
    int cut;
    sent      = 0;
    next_hold = 500;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_hold) begin
        hold_req  = 1'b1;
        next_hold += 500;
      end
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        // noise
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          sent++;
        end
      end else begin
        build_message($urandom_range(1, 5));
        if (kind < 30) begin
          msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind < 40) begin
          cut = $urandom_range(1, msg_bytes.size());
          while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
        end
        send_message(kind >= 95 ? 1'b0 : 1'b1);
        sent += msg_bytes.size();
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
  endtask

  // Output stall: random patterns, plus a long hold-off on request
  initial begin : drive_out_stall
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (mode_left <= 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 120);
      end
      mode_left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 70);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_scan_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", out_data_o));
      end else begin
        want = expected_scan_q.pop_front();
        if (out_data_o.status !== want.status)
          report($sformatf("status %0d, expected %0d", out_data_o.status, want.status));
        if (out_data_o.pair_valid !== want.pair_valid)
          report($sformatf("pair_valid %b, expected %b", out_data_o.pair_valid,
                           want.pair_valid));
        if (out_data_o.key_pos !== want.key_pos)
          report($sformatf("key_pos %0d, expected %0d", out_data_o.key_pos, want.key_pos));
        if (out_data_o.key_len !== want.key_len)
          report($sformatf("key_len %0d, expected %0d", out_data_o.key_len, want.key_len));
        if (out_data_o.value_pos !== want.value_pos)
          report($sformatf("value_pos %0d, expected %0d", out_data_o.value_pos,
                           want.value_pos));
        if (out_data_o.value_len !== want.value_len)
          report($sformatf("value_len %0d, expected %0d", out_data_o.value_len,
                           want.value_len));
      end
    end
  end

  initial begin : run_tests
    int waited;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    waited         = 0;
    clear_scan();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_no_start_mark();
    test_pairs_and_blanks();
    test_stage_errors();
    test_restart();
    test_overflow();
    test_backpressure();
    test_random_messages();

    // Drain outstanding results
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_scan_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_scan_q.size() != 0)
      report($sformatf("%0d results never arrived", expected_scan_q.size()));
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
